/* rtl/banked_set_assoc_cache_lru_assert.svh */
// Assertion macros for the cache RTL.
`ifndef BANKED_SET_ASSOC_CACHE_LRU_ASSERT_SVH
`define BANKED_SET_ASSOC_CACHE_LRU_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define BSAC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define BSAC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bsac_pkg.sv */
`default_nettype none
package bsac_pkg;

    // Field and storage widths
    localparam int ADDR_W     = 64;
    localparam int TAG_W      = 62;
    localparam int STAMP_W    = 32;
    localparam int CNT_W      = 32;
    localparam int NUM_WAYS   = 8;
    localparam int WAY_W      = 3;
    localparam int WAYS_W     = 4;
    localparam int SET_W      = 6;
    localparam int ROW_AW     = 1 + SET_W;
    localparam int NUM_ROWS   = 1 << ROW_AW;
    localparam int IB_W       = 3;
    localparam int OB_W       = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd2;

    // Outcome codes
    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    // Classified access handed from front to back
    typedef struct packed {
        logic              bank;
        logic [SET_W-1:0]  set;
        logic [TAG_W-1:0]  tag;
        logic [WAYS_W-1:0] ways;
    } t_item;

    // One way of a stored row
    typedef struct packed {
        logic [TAG_W-1:0]   tag;
        logic [STAMP_W-1:0] stamp;
    } t_way;

    // One set of one bank
    typedef struct packed {
        logic [NUM_WAYS-1:0] vld;
        t_way [NUM_WAYS-1:0] way;
    } t_row;

    // Result item
    typedef struct packed {
        logic [1:0]       outcome;
        logic [WAY_W-1:0] way_used;
        logic [CNT_W-1:0] hit_total;
        logic [CNT_W-1:0] miss_total;
        logic [CNT_W-1:0] eviction_total;
    } t_result;

    // Saturating increment for stamps and totals
    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage
`default_nettype wire

/* rtl/bsac_front.sv */
`default_nettype none
module bsac_front (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bsac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bsac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             i_push,
    input  wire logic [bsac_pkg::ADDR_W-1:0]      i_address,
    output logic                                  o_full,
    output logic                                  o_valid,
    output bsac_pkg::t_item                       o_item,
    input  wire logic                             i_pop
);

    // Configuration registers
    logic [bsac_pkg::IB_W-1:0]   r_index_bits;
    logic [bsac_pkg::OB_W-1:0]   r_offset_bits;
    logic [bsac_pkg::WAYS_W-1:0] r_ways_in_use;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index_bits  <= bsac_pkg::IB_W'(1);
            r_offset_bits <= bsac_pkg::OB_W'(1);
            r_ways_in_use <= bsac_pkg::WAYS_W'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsac_pkg::CFG_INDEX_BITS:  r_index_bits  <= i_cfg_data[bsac_pkg::IB_W-1:0];
                bsac_pkg::CFG_OFFSET_BITS: r_offset_bits <= i_cfg_data[bsac_pkg::OB_W-1:0];
                bsac_pkg::CFG_WAYS_IN_USE: r_ways_in_use <= i_cfg_data[bsac_pkg::WAYS_W-1:0];
                default: ;
            endcase
        end
    end

    // Address split: bank, set index and tag
    logic [bsac_pkg::ADDR_W-1:0] w_set_sh;
    logic [bsac_pkg::ADDR_W-1:0] w_tag_sh;
    logic [bsac_pkg::SET_W-1:0]  w_mask;
    logic [bsac_pkg::SET_W-1:0]  w_tag_shamt;
    bsac_pkg::t_item             n_item;

    always_comb begin
        w_set_sh    = i_address >> r_offset_bits;
        // index widths of SET_W and above wrap to an all-ones mask
        w_mask      = (bsac_pkg::SET_W'(1) << r_index_bits) - bsac_pkg::SET_W'(1);
        w_tag_shamt = bsac_pkg::SET_W'(r_index_bits) + bsac_pkg::SET_W'(r_offset_bits);
        w_tag_sh    = i_address >> w_tag_shamt;
        n_item.bank = i_address[0];
        n_item.set  = w_set_sh[bsac_pkg::SET_W-1:0] & w_mask;
        n_item.tag  = w_tag_sh[bsac_pkg::TAG_W-1:0];
        // clamp associativity to 1..NUM_WAYS
        if (r_ways_in_use == '0) begin
            n_item.ways = bsac_pkg::WAYS_W'(1);
        end else if (r_ways_in_use > bsac_pkg::WAYS_W'(bsac_pkg::NUM_WAYS)) begin
            n_item.ways = bsac_pkg::WAYS_W'(bsac_pkg::NUM_WAYS);
        end else begin
            n_item.ways = r_ways_in_use;
        end
    end

    // Two-entry queue towards the back end
    bsac_pkg::t_item r_q [2];
    logic            r_wp;
    logic            r_rp;
    logic [1:0]      r_cnt;
    logic            w_wr;
    logic            w_rd;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_q[r_rp];
    assign w_wr    = i_push && !o_full;
    assign w_rd    = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_q[r_wp] <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_wr) begin
                r_wp <= ~r_wp;
            end
            if (w_rd) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_wr) - 2'(w_rd);
        end
    end

endmodule
`default_nettype wire

/* rtl/bsac_back.sv */
`default_nettype none
`include "banked_set_assoc_cache_lru_assert.svh"
module bsac_back (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    input  wire bsac_pkg::t_item  i_item,
    output logic                  o_pop,
    output logic                  o_empty,
    input  wire logic             i_res_pop,
    output bsac_pkg::t_result     o_result
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CMP  = 3'b010,
        S_WR   = 3'b100
    } t_state;

    t_state                            r_state;
    bsac_pkg::t_item                   r_item;
    bsac_pkg::t_row                    r_rdata;
    logic                              r_rvld;
    logic [bsac_pkg::NUM_ROWS-1:0]     r_row_vld;
    bsac_pkg::t_row                    r_mem [bsac_pkg::NUM_ROWS];

    logic [bsac_pkg::STAMP_W-1:0]      r_stamp;
    logic [bsac_pkg::CNT_W-1:0]        r_hits;
    logic [bsac_pkg::CNT_W-1:0]        r_misses;
    logic [bsac_pkg::CNT_W-1:0]        r_evicts;

    logic [1:0]                        r_ocnt;
    logic                              r_owp;
    logic                              r_orp;
    bsac_pkg::t_result                 r_ofifo [2];

    logic                              w_start;
    logic [bsac_pkg::ROW_AW-1:0]       w_raddr;
    logic [bsac_pkg::ROW_AW-1:0]       w_waddr;

    // Take the next access when idle and the result queue has room
    assign w_start = (r_state == S_IDLE) && i_valid && (r_ocnt != 2'd2);
    assign o_pop   = w_start;
    assign w_raddr = {i_item.bank, i_item.set};
    assign w_waddr = {r_item.bank, r_item.set};

    // Compare stage: hit search, free-way search and LRU tree
    logic [bsac_pkg::NUM_WAYS-1:0] w_vld;
    logic [bsac_pkg::NUM_WAYS-1:0] w_in;
    logic [bsac_pkg::NUM_WAYS-1:0] w_hitv;
    logic [bsac_pkg::NUM_WAYS-1:0] w_freev;
    logic [bsac_pkg::WAY_W-1:0]    w_hit_way;
    logic [bsac_pkg::WAY_W-1:0]    w_free_way;
    logic                          l1_c   [4];
    logic [bsac_pkg::WAY_W-1:0]    l1_idx [4];
    logic [bsac_pkg::STAMP_W-1:0]  l1_st  [4];
    logic                          l2_c   [2];
    logic [bsac_pkg::WAY_W-1:0]    l2_idx [2];
    logic [bsac_pkg::STAMP_W-1:0]  l2_st  [2];
    logic [bsac_pkg::WAY_W-1:0]    w_lru_way;

    always_comb begin
        // a row never written reads as all ways invalid
        w_vld = r_rvld ? r_rdata.vld : '0;
        for (int w = 0; w < bsac_pkg::NUM_WAYS; w++) begin
            w_in[w]    = bsac_pkg::WAYS_W'(w) < r_item.ways;
            w_hitv[w]  = w_in[w] && w_vld[w] && (r_rdata.way[w].tag == r_item.tag);
            w_freev[w] = w_in[w] && !w_vld[w];
        end
        // lowest-numbered way wins
        w_hit_way  = '0;
        w_free_way = '0;
        for (int w = bsac_pkg::NUM_WAYS - 1; w >= 0; w--) begin
            if (w_hitv[w]) begin
                w_hit_way = bsac_pkg::WAY_W'(w);
            end
            if (w_freev[w]) begin
                w_free_way = bsac_pkg::WAY_W'(w);
            end
        end
        // oldest stamp, left (lower way) kept on ties
        for (int i = 0; i < 4; i++) begin
            if (w_in[2*i] && (!w_in[2*i+1] ||
                r_rdata.way[2*i].stamp <= r_rdata.way[2*i+1].stamp)) begin
                l1_c[i]   = w_in[2*i];
                l1_idx[i] = bsac_pkg::WAY_W'(2*i);
                l1_st[i]  = r_rdata.way[2*i].stamp;
            end else begin
                l1_c[i]   = w_in[2*i+1];
                l1_idx[i] = bsac_pkg::WAY_W'(2*i+1);
                l1_st[i]  = r_rdata.way[2*i+1].stamp;
            end
        end
        for (int i = 0; i < 2; i++) begin
            if (l1_c[2*i] && (!l1_c[2*i+1] || l1_st[2*i] <= l1_st[2*i+1])) begin
                l2_c[i]   = l1_c[2*i];
                l2_idx[i] = l1_idx[2*i];
                l2_st[i]  = l1_st[2*i];
            end else begin
                l2_c[i]   = l1_c[2*i+1];
                l2_idx[i] = l1_idx[2*i+1];
                l2_st[i]  = l1_st[2*i+1];
            end
        end
        if (l2_c[0] && (!l2_c[1] || l2_st[0] <= l2_st[1])) begin
            w_lru_way = l2_idx[0];
        end else begin
            w_lru_way = l2_idx[1];
        end
    end

    // Compare results held for the write stage
    logic                          r_hit;
    logic                          r_free;
    logic [bsac_pkg::WAY_W-1:0]    r_hit_way;
    logic [bsac_pkg::WAY_W-1:0]    r_free_way;
    logic [bsac_pkg::WAY_W-1:0]    r_lru_way;
    logic [bsac_pkg::NUM_WAYS-1:0] r_vld_m;

    always_ff @(posedge i_clk) begin
        if (r_state == S_CMP) begin
            r_hit      <= |w_hitv;
            r_free     <= |w_freev;
            r_hit_way  <= w_hit_way;
            r_free_way <= w_free_way;
            r_lru_way  <= w_lru_way;
            r_vld_m    <= w_vld;
        end
    end

    // Write stage: choose way, update row and totals
    logic [bsac_pkg::WAY_W-1:0]   w_pick;
    logic [1:0]                   w_outcome;
    logic [bsac_pkg::STAMP_W-1:0] n_stamp;
    logic [bsac_pkg::CNT_W-1:0]   n_hits;
    logic [bsac_pkg::CNT_W-1:0]   n_misses;
    logic [bsac_pkg::CNT_W-1:0]   n_evicts;
    bsac_pkg::t_row               n_row;
    bsac_pkg::t_result            n_result;

    always_comb begin
        n_stamp  = bsac_pkg::sat_inc(r_stamp);
        n_hits   = r_hits;
        n_misses = r_misses;
        n_evicts = r_evicts;
        if (r_hit) begin
            w_pick    = r_hit_way;
            w_outcome = bsac_pkg::OUT_HIT;
            n_hits    = bsac_pkg::sat_inc(r_hits);
        end else if (r_free) begin
            w_pick    = r_free_way;
            w_outcome = bsac_pkg::OUT_FILL;
            n_misses  = bsac_pkg::sat_inc(r_misses);
        end else begin
            w_pick    = r_lru_way;
            w_outcome = bsac_pkg::OUT_EVICT;
            n_misses  = bsac_pkg::sat_inc(r_misses);
            n_evicts  = bsac_pkg::sat_inc(r_evicts);
        end
        n_row                    = r_rdata;
        n_row.vld                = r_vld_m;
        n_row.vld[w_pick]        = 1'b1;
        n_row.way[w_pick].tag    = r_item.tag;
        n_row.way[w_pick].stamp  = n_stamp;
        n_result.outcome         = w_outcome;
        n_result.way_used        = w_pick;
        n_result.hit_total       = n_hits;
        n_result.miss_total      = n_misses;
        n_result.eviction_total  = n_evicts;
    end

    // Set storage: one row per bank and set, read then written back
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_rdata <= r_mem[w_raddr];
            r_rvld  <= r_row_vld[w_raddr];
            r_item  <= i_item;
        end
        if (r_state == S_WR) begin
            r_mem[w_waddr] <= n_row;
        end
    end

    // Sequencer, row valid bits and running totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_row_vld <= '0;
            r_stamp   <= bsac_pkg::STAMP_W'(1);
            r_hits    <= '0;
            r_misses  <= '0;
            r_evicts  <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_start) begin
                        r_state <= S_CMP;
                    end
                end
                S_CMP: r_state <= S_WR;
                S_WR: begin
                    r_state            <= S_IDLE;
                    r_row_vld[w_waddr] <= 1'b1;
                    r_stamp            <= n_stamp;
                    r_hits             <= n_hits;
                    r_misses           <= n_misses;
                    r_evicts           <= n_evicts;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Result queue, two entries
    logic w_opush;
    logic w_opop;

    assign w_opush  = (r_state == S_WR);
    assign w_opop   = i_res_pop && (r_ocnt != 2'd0);
    assign o_empty  = (r_ocnt == 2'd0);
    assign o_result = r_ofifo[r_orp];

    always_ff @(posedge i_clk) begin
        if (w_opush) begin
            r_ofifo[r_owp] <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (w_opush) begin
                r_owp <= ~r_owp;
            end
            if (w_opop) begin
                r_orp <= ~r_orp;
            end
            r_ocnt <= r_ocnt + 2'(w_opush) - 2'(w_opop);
        end
    end

    // Checks
    `BSAC_ASSERT_IMP(a_ofifo_room, i_clk, i_rst_n, r_state == S_WR, r_ocnt != 2'd2, "result queue overflow")
    `BSAC_ASSERT_IMP(a_stamp_mono, i_clk, i_rst_n, $past(i_rst_n), r_stamp >= $past(r_stamp), "stamp went back")
    `BSAC_ASSERT_IMP(a_pick_range, i_clk, i_rst_n, r_state == S_WR, bsac_pkg::WAYS_W'(w_pick) < r_item.ways, "way out of range")
    `BSAC_ASSERT_NXT(a_ways_clamp, i_clk, i_rst_n, w_start, (r_item.ways != '0) && (r_item.ways <= bsac_pkg::WAYS_W'(bsac_pkg::NUM_WAYS)), "bad way count")

endmodule
`default_nettype wire

/* rtl/banked_set_assoc_cache_lru.sv */
// Tag-only two-bank set-associative cache with LRU replacement.
// Accesses come in on a queue-like port: i_address is transferred at a
// rising edge where push is high and full is low. Results leave the same
// way: while empty is low the oldest result sits on o_outcome, o_way_used
// and the three running totals, and it is transferred when pop is high.
// Configuration (index bits, offset bits, ways in use) is written through
// i_cfg_we / i_cfg_idx / i_cfg_data, one register per cycle, no wait.
// A front end classifies each address into bank, set and tag and keeps
// two of them queued; a back end reads the whole set row, compares and
// picks the way, then writes the row back. Each access occupies the back
// end through three steps (pop and row read, compare, write back) and the
// row memory is not touched by the next access until the write is done,
// so the back end takes no new access until the last one is written back,
// when its result enters the result queue.
// When pop stays low the two-entry result queue fills, the back end
// stops, then the front queue fills and full rises.
// Reset (i_rst_n low, synchronous) empties both queues, marks every set
// row invalid at once, zeroes the totals and sets the stamp counter to one.
`default_nettype none
module banked_set_assoc_cache_lru (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             i_cfg_we,
    input  wire logic [bsac_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [bsac_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  wire logic                             push,
    input  wire logic [bsac_pkg::ADDR_W-1:0]      i_address,
    output logic                                  full,
    output logic                                  empty,
    input  wire logic                             pop,
    output logic [1:0]                            o_outcome,
    output logic [bsac_pkg::WAY_W-1:0]            o_way_used,
    output logic [bsac_pkg::CNT_W-1:0]            o_hit_total,
    output logic [bsac_pkg::CNT_W-1:0]            o_miss_total,
    output logic [bsac_pkg::CNT_W-1:0]            o_eviction_total
);

    logic              w_valid;
    logic              w_pop;
    bsac_pkg::t_item   w_item;
    bsac_pkg::t_result w_result;

    // Classification and access queue
    bsac_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_push     (push),
        .i_address  (i_address),
        .o_full     (full),
        .o_valid    (w_valid),
        .o_item     (w_item),
        .i_pop      (w_pop)
    );

    // Lookup, replacement and result queue
    bsac_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_valid),
        .i_item    (w_item),
        .o_pop     (w_pop),
        .o_empty   (empty),
        .i_res_pop (pop),
        .o_result  (w_result)
    );

    assign o_outcome        = w_result.outcome;
    assign o_way_used       = w_result.way_used;
    assign o_hit_total      = w_result.hit_total;
    assign o_miss_total     = w_result.miss_total;
    assign o_eviction_total = w_result.eviction_total;

endmodule
`default_nettype wire
